>>> hw/rtl/sst_pkg.sv
// shared types, sizes and codes of the scoped symbol table
`default_nettype none

package sst_pkg;

    // sizing
    localparam int MAX_ENTRIES  = 64;
    localparam int MAX_SCOPES   = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int SCOPE_CNT_W = $clog2(MAX_SCOPES + 1);
    localparam int LEVEL_W     = $clog2(MAX_SCOPES);

    // port field widths
    localparam int PAY_FIELD_W   = 32;
    localparam int LEVEL_FIELD_W = 4;
    localparam int COUNT_FIELD_W = 5;
    localparam int S_TDATA_W     = 64;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 48;
    localparam int M_TUSER_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH         = 3'd0,
        OP_POP          = 3'd1,
        OP_DECLARE      = 3'd2,
        OP_LOOKUP       = 3'd3,
        OP_LOOKUP_LOCAL = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_DUP       = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_UNDERFLOW = 3'd3,
        STS_FULL      = 3'd4,
        STS_DEPTH     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one slot of the symbol store
    typedef struct packed {
        logic [LEVEL_W-1:0]      level;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [KEY_W-1:0]        key;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/sst_ctrl.sv
// controller state machine of the scoped symbol table
`default_nettype none

module sst_ctrl
    import sst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dp_status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.commit = dp_status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // a result is only written into a free output slot
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> dp_status.out_free)
        else $error("commit while output slot is taken");

    // an accepted item always starts a scan
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_SCAN)
        else $error("accepted beat did not enter scan");

    // no new beat is taken while an item is in work
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.commit) |-> !in_ready)
        else $error("ready raised during work on an item");

endmodule

`default_nettype wire

>>> hw/rtl/sst_datapath.sv
// symbol store, scope starts, scan pointer and result register
`default_nettype none

module sst_datapath
    import sst_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctrl_cmd_t                cmd,
    output dp_status_t                    dp_status,
    input  wire logic [OP_W-1:0]          in_opcode,
    input  wire logic [KEY_W-1:0]         in_key,
    input  wire logic [PAY_FIELD_W-1:0]   in_payload,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [STATUS_W-1:0]           out_status,
    output logic                          out_found,
    output logic [PAY_FIELD_W-1:0]        out_payload,
    output logic [LEVEL_FIELD_W-1:0]      out_level,
    output logic [COUNT_FIELD_W-1:0]      out_count
);

    // item registers
    op_t                     op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // table state
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [SCOPE_CNT_W-1:0]  open_reg;
    logic [SCOPE_CNT_W-1:0]  open_next;
    logic [CNT_W-1:0]        scope_start_reg [MAX_SCOPES];
    entry_t                  mem [MAX_ENTRIES];

    // scan state
    logic [CNT_W-1:0]        lo_reg;
    logic [CNT_W-1:0]        lo_next;
    logic [CNT_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        ptr_m1;
    logic                    rd_valid_reg;
    entry_t                  rd_data_reg;
    logic                    rd_en;
    logic                    match;
    logic                    scan_done;
    logic                    hit_reg;
    logic [PAYLOAD_BITS-1:0] hit_pay_reg;
    logic [LEVEL_W-1:0]      hit_lvl_reg;

    // commit decode
    logic [SCOPE_CNT_W-1:0]  open_m1;
    logic [CNT_W-1:0]        inner_start;
    logic                    ss_we;
    logic [LEVEL_W-1:0]      ss_widx;
    logic                    mem_we;
    entry_t                  mem_wdata;
    status_t                 sts;
    logic                    found;
    logic [PAYLOAD_BITS-1:0] fpay;
    logic [LEVEL_W-1:0]      flvl;

    // result register
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic                    out_found_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic [LEVEL_W-1:0]      out_lvl_reg;
    logic [SCOPE_CNT_W-1:0]  out_cnt_reg;

    // start of the innermost scope
    assign open_m1     = open_reg - 1'b1;
    assign inner_start = scope_start_reg[open_m1[LEVEL_W-1:0]];

    // lower bound of the search range for a new item
    always_comb
    begin
        lo_next = count_reg;
        case (op_t'(in_opcode)) inside
            OP_LOOKUP:
            begin
                lo_next = '0;
            end
            OP_DECLARE, OP_LOOKUP_LOCAL:
            begin
                if (open_reg != '0)
                begin
                    lo_next = inner_start;
                end
            end
            default:
            begin
                lo_next = count_reg;
            end
        endcase
    end

    // scan: one read per cycle, newest entry first
    assign ptr_m1    = ptr_reg - 1'b1;
    assign rd_en     = cmd.scan && (ptr_reg > lo_reg);
    assign match     = rd_valid_reg && (rd_data_reg.key == key_reg);
    assign scan_done = match || (!rd_valid_reg && (ptr_reg == lo_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= op_t'(in_opcode);
            key_reg <= in_key;
            pay_reg <= in_payload[PAYLOAD_BITS-1:0];
            lo_reg  <= lo_next;
            ptr_reg <= count_reg;
        end
        else if (rd_en)
        begin
            ptr_reg <= ptr_m1;
        end
        if (cmd.scan && scan_done)
        begin
            hit_reg     <= match;
            hit_pay_reg <= rd_data_reg.payload;
            hit_lvl_reg <= rd_data_reg.level;
        end
    end

    // symbol store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_m1[ADDR_W-1:0]];
        end
    end

    // effect of the item on the table and its result
    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        ss_we      = 1'b0;
        ss_widx    = open_reg[LEVEL_W-1:0];
        mem_we     = 1'b0;
        mem_wdata  = '{level: open_m1[LEVEL_W-1:0], payload: pay_reg, key: key_reg};
        sts        = STS_OK;
        found      = 1'b0;
        fpay       = '0;
        flvl       = '0;
        unique case (op_reg)
            OP_PUSH:
            begin
                if (open_reg >= SCOPE_CNT_W'(MAX_SCOPES))
                begin
                    sts = STS_DEPTH;
                end
                else
                begin
                    ss_we     = 1'b1;
                    open_next = open_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (open_reg == '0)
                begin
                    sts = STS_UNDERFLOW;
                end
                else
                begin
                    open_next  = open_m1;
                    count_next = inner_start;
                end
            end
            OP_DECLARE:
            begin
                if (hit_reg)
                begin
                    sts = STS_DUP;
                end
                else if (count_reg >= CNT_W'(MAX_ENTRIES))
                begin
                    sts = STS_FULL;
                end
                else
                begin
                    // no scope open: the outermost one opens here
                    if (open_reg == '0)
                    begin
                        ss_we           = 1'b1;
                        ss_widx         = '0;
                        open_next       = SCOPE_CNT_W'(1);
                        mem_wdata.level = '0;
                    end
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_LOOKUP, OP_LOOKUP_LOCAL:
            begin
                if (hit_reg)
                begin
                    found = 1'b1;
                    fpay  = hit_pay_reg;
                    flvl  = hit_lvl_reg;
                end
                else
                begin
                    sts = STS_NOT_FOUND;
                end
            end
            default:
            begin
                sts = STS_OK;
            end
        endcase
    end

    // table counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    // scope start array
    always_ff @(posedge clk)
    begin
        if (cmd.commit && ss_we)
        begin
            scope_start_reg[ss_widx] <= count_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= sts;
            out_found_reg  <= found;
            out_pay_reg    <= fpay;
            out_lvl_reg    <= flvl;
            out_cnt_reg    <= open_next;
        end
    end

    assign dp_status.scan_done = scan_done;
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_found   = out_found_reg;
    assign out_payload = PAY_FIELD_W'(out_pay_reg);
    assign out_level   = LEVEL_FIELD_W'(out_lvl_reg);
    assign out_count   = COUNT_FIELD_W'(out_cnt_reg);

    // store writes decode only from a declare
    a_mem_we_commit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> op_reg == OP_DECLARE)
        else $error("store write decoded outside a declare");

    // depth and fill stay in range
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg <= SCOPE_CNT_W'(MAX_SCOPES)) && (count_reg <= CNT_W'(MAX_ENTRIES)))
        else $error("scope depth or entry count out of range");

    // scan never runs below the range bound
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (ptr_reg >= lo_reg) && (lo_reg <= count_reg))
        else $error("scan pointer below range bound");

    // table state moves only at commit
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg) && $stable(open_reg))
        else $error("table state changed without commit");

endmodule

`default_nettype wire

>>> hw/rtl/scoped_symbol_table.sv
// top level of the scoped symbol table
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: opcode; tdata: key, payload
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status, found;
//                                              tdata: payload, level, scope count
//
// push, pop, declare into an empty scope and unused opcodes give their result without
// reading the store; a search reads the symbol store through its one read port,
// one entry per cycle,
// newest first, and stops at the first match.
// one item is in work at a time; the next beat is taken once the result is in
// the output register, even while that result still waits on m_axis_tready.
// reset empties the table at once (no clearing pass) and drops any pending result.
`default_nettype none

module scoped_symbol_table
    import sst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] symbol_key, [63:32] symbol_payload
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] opcode
    input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] found_payload, [35:32] found_level, [40:36] scope_count, [47:41] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // [2:0] status, [3] found
    output logic [M_TUSER_W-1:0]       m_axis_tuser
);

    ctrl_cmd_t                  cmd;
    dp_status_t                 dp_status;
    logic [STATUS_W-1:0]        out_status;
    logic                       out_found;
    logic [PAY_FIELD_W-1:0]     out_payload;
    logic [LEVEL_FIELD_W-1:0]   out_level;
    logic [COUNT_FIELD_W-1:0]   out_count;

    // sequencing
    sst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // storage and search
    sst_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .in_opcode   (s_axis_tuser[OP_W-1:0]),
        .in_key      (s_axis_tdata[KEY_W-1:0]),
        .in_payload  (s_axis_tdata[KEY_W+PAY_FIELD_W-1:KEY_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .out_found   (out_found),
        .out_payload (out_payload),
        .out_level   (out_level),
        .out_count   (out_count)
    );

    // result beat packing
    assign m_axis_tuser = {out_found, out_status};
    assign m_axis_tdata = {{(M_TDATA_W - PAY_FIELD_W - LEVEL_FIELD_W - COUNT_FIELD_W){1'b0}},
                           out_count, out_level, out_payload};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench of the scoped symbol table: directed table, then random scope sequences vs a predictor
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS    = 390;
    localparam int N_PHASES       = 4;
    localparam int N_DIRECTED     = 22;

    // opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // one result beat, split into its fields
    typedef struct packed {
        status_t                  status;
        logic                     found;
        logic [PAY_FIELD_W-1:0]   payload;
        logic [LEVEL_FIELD_W-1:0] level;
        logic [COUNT_FIELD_W-1:0] scopes;
    } answer_t;

    // one row of the directed table
    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [KEY_W-1:0]       key;
        logic [PAY_FIELD_W-1:0] pay;
        logic                   typed;
        answer_t                want;
    } vector_t;

    localparam answer_t BLANK = '{STS_OK, 1'b0, 32'h0, 4'h0, 5'd0};

    // directed rows: the typed ones carry their answer, the others go to the predictor
    vector_t directed [N_DIRECTED] = '{
        '{OP_LOOKUP,       32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STS_NOT_FOUND, 1'b0, 32'h0, 4'h0, 5'd0}},
        '{OP_LOOKUP_LOCAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STS_NOT_FOUND, 1'b0, 32'h0, 4'h0, 5'd0}},
        '{OP_POP,          32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STS_UNDERFLOW, 1'b0, 32'h0, 4'h0, 5'd0}},
        '{OP_SPARE_HI,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STS_OK, 1'b0, 32'h0, 4'h0, 5'd0}},
        '{OP_DECLARE,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{STS_OK, 1'b0, 32'h0, 4'h0, 5'd1}},
        '{OP_DECLARE,      32'h0000_0000, 32'h0000_1234, 1'b1,
          '{STS_DUP, 1'b0, 32'h0, 4'h0, 5'd1}},
        '{OP_LOOKUP,       32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STS_OK, 1'b1, 32'hFFFF_FFFF, 4'h0, 5'd1}},
        '{OP_PUSH,         32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STS_OK, 1'b0, 32'h0, 4'h0, 5'd2}},
        '{OP_DECLARE,      32'h0000_0000, 32'h0000_0000, 1'b0, BLANK},
        '{OP_LOOKUP,       32'h0000_0000, 32'hFFFF_FFFF, 1'b0, BLANK},
        '{OP_LOOKUP_LOCAL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, BLANK},
        '{OP_DECLARE,      32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0, BLANK},
        '{OP_LOOKUP_LOCAL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, BLANK},
        '{OP_LOOKUP_LOCAL, 32'h0000_0000, 32'h0000_0000, 1'b0, BLANK},
        '{OP_POP,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, BLANK},
        '{OP_LOOKUP,       32'hFFFF_FFFF, 32'h0000_0000, 1'b0, BLANK},
        '{OP_LOOKUP,       32'h0000_0000, 32'h0000_0000, 1'b0, BLANK},
        '{OP_SPARE_LO,     32'h5A5A_A5A5, 32'h0F0F_F0F0, 1'b0, BLANK},
        '{OP_POP,          32'h0000_0000, 32'h0000_0000, 1'b0, BLANK},
        '{OP_POP,          32'h0000_0000, 32'h0000_0000, 1'b1,
          '{STS_UNDERFLOW, 1'b0, 32'h0, 4'h0, 5'd0}},
        '{OP_DECLARE,      32'h0000_0001, 32'h8000_0001, 1'b0, BLANK},
        '{OP_POP,          32'h0000_0000, 32'h0000_0000, 1'b0, BLANK}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // predictor copy of the table
    logic [KEY_W-1:0]         sym_key [MAX_ENTRIES];
    logic [PAY_FIELD_W-1:0]   sym_pay [MAX_ENTRIES];
    logic [LEVEL_FIELD_W-1:0] sym_lvl [MAX_ENTRIES];
    int                       scope_base [MAX_SCOPES];
    int                       sym_cnt;
    int                       depth;

    answer_t          answers_due [$];
    answer_t          rx_want;
    logic [KEY_W-1:0] key_pool [8];
    int               mismatches;
    int               results_seen;
    int               sent_total;
    int               cycle_count;
    int               src_idle_now;
    int               rx_stall_now;
    bit               hold_armed;
    bit               hold_served;

    scoped_symbol_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic note_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
        mismatches++;
    endtask

    // newest-first search of entries from lo up to the fill mark
    function automatic int find_newest(input int lo, input logic [KEY_W-1:0] key);
        for (int i = sym_cnt - 1; i >= lo; i--)
        begin
            if (sym_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // apply one item to the predictor table and give the answer it causes
    function automatic answer_t table_answer(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] key,
                                             input logic [PAY_FIELD_W-1:0] pay);
        answer_t a;
        int      hit;
        a   = BLANK;
        hit = -1;
        case (op)
            OP_PUSH:
            begin
                if (depth >= MAX_SCOPES)
                    a.status = STS_DEPTH;
                else
                begin
                    scope_base[depth] = sym_cnt;
                    depth++;
                end
            end
            OP_POP:
            begin
                if (depth == 0)
                    a.status = STS_UNDERFLOW;
                else
                begin
                    depth--;
                    sym_cnt = scope_base[depth];
                end
            end
            OP_DECLARE:
            begin
                if (depth > 0)
                    hit = find_newest(scope_base[depth - 1], key);
                if (hit >= 0)
                    a.status = STS_DUP;
                else if (sym_cnt >= MAX_ENTRIES)
                    a.status = STS_FULL;
                else
                begin
                    // first declare with no scope open opens the outermost one
                    if (depth == 0)
                    begin
                        scope_base[0] = sym_cnt;
                        depth = 1;
                    end
                    sym_key[sym_cnt] = key;
                    sym_pay[sym_cnt] = pay;
                    sym_lvl[sym_cnt] = LEVEL_FIELD_W'(depth - 1);
                    sym_cnt++;
                end
            end
            OP_LOOKUP, OP_LOOKUP_LOCAL:
            begin
                if (op == OP_LOOKUP)
                    hit = find_newest(0, key);
                else if (depth > 0)
                    hit = find_newest(scope_base[depth - 1], key);
                if (hit >= 0)
                begin
                    a.found   = 1'b1;
                    a.payload = sym_pay[hit];
                    a.level   = sym_lvl[hit];
                end
                else
                    a.status = STS_NOT_FOUND;
            end
            default: ;
        endcase
        a.scopes = COUNT_FIELD_W'(depth);
        return a;
    endfunction

    // offer one beat at a falling edge, hold it until taken, then log its answer
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [PAY_FIELD_W-1:0] pay, input logic typed,
                             input answer_t want);
        answer_t a;
        while ($urandom_range(99) < src_idle_now)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pay, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        a = table_answer(op, key, pay);
        if (typed)
            a = want;
        answers_due = {answers_due, a};
        sent_total++;
        @(negedge clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [PAY_FIELD_W-1:0] pay);
        send_item(op, key, pay, 1'b0, BLANK);
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(7)];
    endfunction

    // stop offering and wait until every answer has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // close every open scope
    task automatic unwind();
        while (depth > 0)
            issue(OP_POP, $urandom, $urandom);
    endtask

    // one scope with a few declares and lookups on a small key pool
    task automatic scope_block();
        int n;
        int pick;
        issue(OP_PUSH, $urandom, $urandom);
        n = $urandom_range(6, 1);
        repeat (n)
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                issue(OP_DECLARE, pool_key(), $urandom);
            else if (pick == 1)
                issue(OP_LOOKUP, pool_key(), $urandom);
            else
                issue(OP_LOOKUP_LOCAL, pool_key(), $urandom);
        end
        if ($urandom_range(99) < 80)
            issue(OP_POP, $urandom, $urandom);
    endtask

    // fill the store, hit the full and duplicate checks, search it end to end
    task automatic fill_store();
        issue(OP_PUSH, $urandom, $urandom);
        while (sym_cnt < MAX_ENTRIES)
            issue(OP_DECLARE, $urandom, $urandom);
        issue(OP_DECLARE, $urandom, $urandom);
        issue(OP_DECLARE, sym_key[sym_cnt - 1], $urandom);
        issue(OP_DECLARE, pool_key(), $urandom);
        issue(OP_LOOKUP, pool_key(), $urandom);
        issue(OP_LOOKUP, sym_key[0], $urandom);
        issue(OP_LOOKUP_LOCAL, $urandom, $urandom);
        unwind();
    endtask

    // open scopes up to full depth and past it
    task automatic deep_nest();
        while (depth < MAX_SCOPES)
        begin
            issue(OP_PUSH, $urandom, $urandom);
            if ($urandom_range(1) == 1 && sym_cnt < MAX_ENTRIES)
                issue(OP_DECLARE, pool_key(), $urandom);
        end
        issue(OP_PUSH, $urandom, $urandom);
        issue(OP_PUSH, $urandom, $urandom);
        if (sym_cnt < MAX_ENTRIES)
            issue(OP_DECLARE, pool_key(), $urandom);
        repeat (3)
            issue(OP_LOOKUP, pool_key(), $urandom);
        issue(OP_LOOKUP_LOCAL, pool_key(), $urandom);
        unwind();
    endtask

    // one randomly chosen sequence
    task automatic random_sequence();
        int roll;
        roll = $urandom_range(99);
        if (sym_cnt > 40 || depth > 13)
            unwind();
        if (roll < 58)
            scope_block();
        else if (roll < 68)
            issue(3'($urandom_range(7)), $urandom, $urandom);
        else if (roll < 70)
            fill_store();
        else if (roll < 75)
            deep_nest();
        else
        begin
            repeat ($urandom_range(4, 1))
            begin
                if ($urandom_range(1) == 1)
                    issue(OP_LOOKUP, ($urandom_range(3) == 0) ? $urandom : pool_key(),
                          $urandom);
                else
                    issue(OP_LOOKUP_LOCAL, ($urandom_range(3) == 0) ? $urandom : pool_key(),
                          $urandom);
            end
        end
    endtask

    // receiver: random stall, or one long hold-off counted here
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_served = 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_stall_now);
        end
    end

    // result checker: compare each taken beat with the oldest answer due
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
                note_mismatch("result beat with no answer due");
            else
            begin
                rx_want = answers_due.pop_front();
                if (m_axis_tuser[2:0] !== rx_want.status)
                    note_mismatch($sformatf("status %0d, want %0d",
                                            m_axis_tuser[2:0], rx_want.status));
                if (m_axis_tuser[3] !== rx_want.found)
                    note_mismatch($sformatf("found %0b, want %0b",
                                            m_axis_tuser[3], rx_want.found));
                if (m_axis_tdata[31:0] !== rx_want.payload)
                    note_mismatch($sformatf("payload %08h, want %08h",
                                            m_axis_tdata[31:0], rx_want.payload));
                if (m_axis_tdata[35:32] !== rx_want.level)
                    note_mismatch($sformatf("level %0d, want %0d",
                                            m_axis_tdata[35:32], rx_want.level));
                if (m_axis_tdata[40:36] !== rx_want.scopes)
                    note_mismatch($sformatf("scope count %0d, want %0d",
                                            m_axis_tdata[40:36], rx_want.scopes));
                if (m_axis_tdata[47:41] !== 7'd0)
                    note_mismatch($sformatf("pad bits %02h, want zero",
                                            m_axis_tdata[47:41]));
            end
            results_seen++;
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("scoped_symbol_table: mismatch");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase_start;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        src_idle_now  = 0;
        rx_stall_now  = 0;
        hold_armed    = 1'b0;
        hold_served   = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        sent_total    = 0;
        sym_cnt       = 0;
        depth         = 0;
        key_pool[0]   = 32'h0000_0000;
        key_pool[1]   = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = $urandom;

        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed[i].op, directed[i].key, directed[i].pay,
                      directed[i].typed, directed[i].want);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            phase_start = sent_total;
            while (sent_total < phase_start + PHASE_ITEMS)
            begin
                // stretches with no idling inside each phase
                if ($urandom_range(99) < 15)
                begin
                    src_idle_now = 0;
                    rx_stall_now = 0;
                end
                else
                begin
                    src_idle_now = (ph == 1) ? 83 : (ph == 3) ? 21 : 0;
                    rx_stall_now = (ph == 2) ? 83 : (ph == 3) ? 21 : 0;
                end
                if (ph == 0 && !hold_armed && sent_total >= phase_start + 100)
                    hold_armed = 1'b1;
                random_sequence();
            end
            unwind();
            drain();
        end

        src_idle_now = 0;
        rx_stall_now = 0;
        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (answers_due.size() != 0)
            note_mismatch($sformatf("%0d answers never came", answers_due.size()));

        if (mismatches == 0)
            $display("scoped_symbol_table: match");
        else
            $display("scoped_symbol_table: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
